FILE: hw/rtl/mcs_pkg.sv
package mcs_pkg;

  localparam int PIXEL_BITS = 32;
  localparam int VAL_W      = 33;
  localparam int DIFF_W     = 34;
  localparam int DEN_W      = 33;
  localparam int NUM_W      = 41;
  localparam int REM_W      = 42;
  localparam int QBITS      = 8;
  localparam int LEVEL_W    = 8;

  localparam logic [31:0] RAW_MASK = 32'hFFFF_FFFF >> (32 - PIXEL_BITS);

  localparam logic [2:0] KIND_U8  = 3'd0;
  localparam logic [2:0] KIND_S8  = 3'd1;
  localparam logic [2:0] KIND_U16 = 3'd2;
  localparam logic [2:0] KIND_S16 = 3'd3;
  localparam logic [2:0] KIND_S32 = 3'd4;
  localparam logic [2:0] KIND_U32 = 3'd5;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    logic valid;
    logic err;
    logic zero;
    logic sat;
  } tag_t;

  function automatic val_t type_min(input logic [2:0] kind);
    val_t v;
    case (kind)
      KIND_S8:  v = {{26{1'b1}}, 7'b0};
      KIND_S16: v = {{18{1'b1}}, 15'b0};
      KIND_S32: v = {2'b11, 31'b0};
      default:  v = '0;
    endcase
    return v;
  endfunction

  function automatic val_t type_max(input logic [2:0] kind);
    val_t v;
    case (kind)
      KIND_U8:  v = {25'b0, 8'hFF};
      KIND_S8:  v = {26'b0, 7'h7F};
      KIND_U16: v = {17'b0, 16'hFFFF};
      KIND_S16: v = {18'b0, 15'h7FFF};
      KIND_S32: v = {2'b00, {31{1'b1}}};
      default:  v = {1'b0, {32{1'b1}}};
    endcase
    return v;
  endfunction

  function automatic val_t read_pixel(input logic [31:0] raw, input logic [2:0] kind);
    logic [31:0] x;
    val_t v;
    x = raw & RAW_MASK;
    case (kind)
      KIND_U8:  v = {25'b0, x[7:0]};
      KIND_S8:  v = {{25{x[7]}}, x[7:0]};
      KIND_U16: v = {17'b0, x[15:0]};
      KIND_S16: v = {{17{x[15]}}, x[15:0]};
      KIND_S32: v = {x[31], x};
      default:  v = {1'b0, x};
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/mcs_in_if.sv
interface mcs_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic        first;
  logic [31:0] pixel_bits;

  modport source (output valid, output action, output first, output pixel_bits, input ready);
  modport sink (input valid, input action, input first, input pixel_bits, output ready);
endinterface

FILE: hw/rtl/mcs_out_if.sv
interface mcs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] level;
  logic       range_error;

  modport source (output valid, output level, output range_error, input ready);
  modport sink (input valid, input level, input range_error, output ready);
endinterface

FILE: hw/rtl/minmax_contrast_stretch_8bit_unit.sv
// Min/max contrast stretch of one image plane to 8-bit levels.
// Words arrive on the pixels channel (valid/ready). A measure word (action 0)
// updates the running minimum and maximum of unsaturated pixels and gives no
// result; first restarts the extremes. A map word (action 1) gives one word
// on the levels channel: round((p - min) * 255 / (max - min)), clamped to
// 0..255, or range_error with level 0 when no usable range was measured.
// The user must write pixel_kind through wr_en/wr_data only while no word
// is in flight; the block does not enforce this. A map word passes the
// extreme and difference stage, the scaling and rounding setup registers,
// the row of divider cells (one quotient bit each) and the output register.
// Throughput is one word per cycle while the output register is empty or
// levels.ready is high. The whole pipeline advances together, so while a
// result waits on levels.ready the pipeline and pixels.ready hold.
// Synchronous reset clears all valid bits, sets pixel_kind to u8 and the
// extremes to 255 and 0.
module minmax_contrast_stretch_8bit_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic [2:0] wr_data,
  mcs_in_if.sink     pixels,
  mcs_out_if.source  levels
);
  import mcs_pkg::*;

  logic                      adv;
  logic                      accept;
  logic [2:0]                pixel_kind;
  tag_t                      a_tag, b_tag, c_tag;
  logic signed [DIFF_W-1:0]  a_diff;
  logic [DEN_W-1:0]          a_den, b_den;
  logic [NUM_W-1:0]          b_num;
  logic [REM_W-1:0]          c_rem, c_dsh;
  logic                      zero_flag, sat_flag;
  logic                      o_valid;
  logic [LEVEL_W-1:0]        level;
  logic                      range_error;

  tag_t                      cell_tag [QBITS+1];
  logic [REM_W-1:0]          cell_rem [QBITS+1];
  logic [REM_W-1:0]          cell_dsh [QBITS+1];
  logic [QBITS-1:0]          cell_q   [QBITS+1];

  assign adv           = !o_valid || levels.ready;
  assign accept        = pixels.valid && adv;
  assign pixels.ready  = adv;
  assign levels.valid  = o_valid;
  assign levels.level  = level;
  assign levels.range_error = range_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_kind <= KIND_U8;
    end else if (wr_en) begin
      pixel_kind <= wr_data;
    end
  end

  mcs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .accept     (accept),
    .kind       (pixel_kind),
    .action     (pixels.action),
    .first      (pixels.first),
    .pixel_bits (pixels.pixel_bits),
    .a_tag      (a_tag),
    .a_diff     (a_diff),
    .a_den      (a_den)
  );

  // A pixel at or below the minimum maps to 0; at or above the maximum, to 255.
  // Between them the difference is below the range and the quotient fits 8 bits.
  assign zero_flag = !a_tag.err && (a_diff <= 0);
  assign sat_flag  = !a_tag.err && !zero_flag && (a_diff >= $signed({1'b0, a_den}));

  always_ff @(posedge clk) begin
    if (rst) begin
      b_tag <= '0;
      c_tag <= '0;
    end else if (adv) begin
      b_tag <= '{valid: a_tag.valid, err: a_tag.err, zero: zero_flag, sat: sat_flag};
      c_tag <= b_tag;
    end
  end

  // Rounded quotient: (2*num + den) / (2*den), with num = diff * 255.
  always_ff @(posedge clk) begin
    if (adv) begin
      b_num <= {a_diff[DEN_W-1:0], 8'b0} - NUM_W'(a_diff[DEN_W-1:0]);
      b_den <= a_den;
      c_rem <= (REM_W'(b_num) << 1) + REM_W'(b_den);
      c_dsh <= REM_W'(b_den) << QBITS;
    end
  end

  assign cell_tag[0] = c_tag;
  assign cell_rem[0] = c_rem;
  assign cell_dsh[0] = c_dsh;
  assign cell_q[0]   = '0;

  for (genvar i = 0; i < QBITS; i++) begin : g_cell
    mcs_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .adv    (adv),
      .up_tag (cell_tag[i]),
      .up_rem (cell_rem[i]),
      .up_dsh (cell_dsh[i]),
      .up_q   (cell_q[i]),
      .dn_tag (cell_tag[i+1]),
      .dn_rem (cell_rem[i+1]),
      .dn_dsh (cell_dsh[i+1]),
      .dn_q   (cell_q[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= cell_tag[QBITS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      range_error <= cell_tag[QBITS].err;
      if (cell_tag[QBITS].err || cell_tag[QBITS].zero) begin
        level <= '0;
      end else if (cell_tag[QBITS].sat) begin
        level <= LEVEL_MAX;
      end else begin
        level <= cell_q[QBITS];
      end
    end
  end

  a_map_enters: assert property (@(posedge clk) disable iff (rst)
    pixels.valid && pixels.ready |=> a_tag.valid == $past(pixels.action))
    else $error("map word did not enter the pipeline");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    b_tag.valid && !b_tag.err |-> !(b_tag.zero && b_tag.sat))
    else $error("pixel flagged both below and above range");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cell_tag[QBITS].valid && !cell_tag[QBITS].err && !cell_tag[QBITS].zero &&
    !cell_tag[QBITS].sat |-> cell_rem[QBITS] < (cell_dsh[QBITS] << 1))
    else $error("divider remainder not below divisor");

  a_err_level: assert property (@(posedge clk) disable iff (rst)
    levels.valid && levels.range_error |-> levels.level == '0)
    else $error("range error with nonzero level");

endmodule

FILE: hw/rtl/mcs_front.sv
module mcs_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                accept,
  input  logic [2:0]                          kind,
  input  logic                                action,
  input  logic                                first,
  input  logic [31:0]                         pixel_bits,
  output mcs_pkg::tag_t                       a_tag,
  output logic signed [mcs_pkg::DIFF_W-1:0]   a_diff,
  output logic [mcs_pkg::DEN_W-1:0]           a_den
);
  import mcs_pkg::*;

  val_t p, tmin, tmax;
  val_t low_extreme, high_extreme, low_next, high_next, low_base, high_base;
  logic signed [DIFF_W-1:0] den_full;

  always_comb begin
    p         = read_pixel(pixel_bits, kind);
    tmin      = type_min(kind);
    tmax      = type_max(kind);
    low_base  = first ? tmax : low_extreme;
    high_base = first ? tmin : high_extreme;
    low_next  = (p > tmin && p < low_base) ? p : low_base;
    high_next = (p < tmax && p > high_base) ? p : high_base;
    den_full  = DIFF_W'(high_extreme) - DIFF_W'(low_extreme);
  end

  // Extremes follow measure words only; saturated pixels never count.
  always_ff @(posedge clk) begin
    if (rst) begin
      low_extreme  <= type_max(KIND_U8);
      high_extreme <= type_min(KIND_U8);
    end else if (accept && !action) begin
      low_extreme  <= low_next;
      high_extreme <= high_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_tag <= '0;
    end else if (adv) begin
      a_tag.valid <= accept && action;
      a_tag.err   <= low_extreme >= high_extreme;
      a_tag.zero  <= 1'b0;
      a_tag.sat   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_diff <= DIFF_W'(p) - DIFF_W'(low_extreme);
      a_den  <= den_full[DEN_W-1:0];
    end
  end

endmodule

FILE: hw/rtl/mcs_cell.sv
module mcs_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  mcs_pkg::tag_t                up_tag,
  input  logic [mcs_pkg::REM_W-1:0]    up_rem,
  input  logic [mcs_pkg::REM_W-1:0]    up_dsh,
  input  logic [mcs_pkg::QBITS-1:0]    up_q,
  output mcs_pkg::tag_t                dn_tag,
  output logic [mcs_pkg::REM_W-1:0]    dn_rem,
  output logic [mcs_pkg::REM_W-1:0]    dn_dsh,
  output logic [mcs_pkg::QBITS-1:0]    dn_q
);
  import mcs_pkg::*;

  logic fit;

  assign fit = up_rem >= up_dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_tag <= '0;
    end else if (adv) begin
      dn_tag <= up_tag;
    end
  end

  // One restoring step: the divisor walks down one bit per cell.
  always_ff @(posedge clk) begin
    if (adv) begin
      dn_rem <= fit ? up_rem - up_dsh : up_rem;
      dn_dsh <= up_dsh >> 1;
      dn_q   <= {up_q[QBITS-2:0], fit};
    end
  end

endmodule
